@@ design/ortest_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, types and latency for the oriented rectangle overlap test.
// No dependencies; every other design file refers to this package by scoped names.

package ortest_pkg;

    localparam int COORD_WIDTH = 16;
    // edge vector component: difference of two corners
    localparam int EDGE_W      = COORD_WIDTH + 1;
    // corner relative to a base corner, fourth corner included
    localparam int REL_W       = COORD_WIDTH + 3;
    localparam int PROD_W      = REL_W + EDGE_W;
    localparam int DOT_W       = PROD_W + 1;
    localparam int LEN_W       = 2 * EDGE_W + 1;
    localparam int CORNERS     = 4;
    localparam int LANES       = 4;
    // front stage, products, sums, compares, axis verdict, result
    localparam int LATENCY     = 6;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic [EDGE_W-1:0]              ex;
        logic [EDGE_W-1:0]              ey;
        logic [CORNERS-1:0][REL_W-1:0]  qx;
        logic [CORNERS-1:0][REL_W-1:0]  qy;
    } lane_in_t;

endpackage

@@ design/ortest_front.sv @@
`timescale 1ns / 1ps
// Front stage: edge vectors of one rectangle and the other rectangle's corners
// relative to its base corner, registered. Depends on ortest_pkg.

module ortest_front (
    input  logic                  clk,
    input  ortest_pkg::coord_t    self_base_x,
    input  ortest_pkg::coord_t    self_base_y,
    input  ortest_pkg::coord_t    self_side_x,
    input  ortest_pkg::coord_t    self_side_y,
    input  ortest_pkg::coord_t    self_up_x,
    input  ortest_pkg::coord_t    self_up_y,
    input  ortest_pkg::coord_t    other_base_x,
    input  ortest_pkg::coord_t    other_base_y,
    input  ortest_pkg::coord_t    other_side_x,
    input  ortest_pkg::coord_t    other_side_y,
    input  ortest_pkg::coord_t    other_up_x,
    input  ortest_pkg::coord_t    other_up_y,
    output ortest_pkg::lane_in_t  side_lane,
    output ortest_pkg::lane_in_t  up_lane
);

    logic signed [ortest_pkg::REL_W-1:0]  cx [ortest_pkg::CORNERS];
    logic signed [ortest_pkg::REL_W-1:0]  cy [ortest_pkg::CORNERS];
    logic signed [ortest_pkg::EDGE_W-1:0] side_ex;
    logic signed [ortest_pkg::EDGE_W-1:0] side_ey;
    logic signed [ortest_pkg::EDGE_W-1:0] up_ex;
    logic signed [ortest_pkg::EDGE_W-1:0] up_ey;
    ortest_pkg::lane_in_t side_lane_next;
    ortest_pkg::lane_in_t up_lane_next;
    ortest_pkg::lane_in_t side_lane_reg;
    ortest_pkg::lane_in_t up_lane_reg;

    always_comb
    begin
        side_ex = ortest_pkg::EDGE_W'(self_side_x) - ortest_pkg::EDGE_W'(self_base_x);
        side_ey = ortest_pkg::EDGE_W'(self_side_y) - ortest_pkg::EDGE_W'(self_base_y);
        up_ex   = ortest_pkg::EDGE_W'(self_up_x) - ortest_pkg::EDGE_W'(self_base_x);
        up_ey   = ortest_pkg::EDGE_W'(self_up_y) - ortest_pkg::EDGE_W'(self_base_y);

        cx[0] = ortest_pkg::REL_W'(other_base_x) - ortest_pkg::REL_W'(self_base_x);
        cy[0] = ortest_pkg::REL_W'(other_base_y) - ortest_pkg::REL_W'(self_base_y);
        cx[1] = ortest_pkg::REL_W'(other_side_x) - ortest_pkg::REL_W'(self_base_x);
        cy[1] = ortest_pkg::REL_W'(other_side_y) - ortest_pkg::REL_W'(self_base_y);
        cx[2] = ortest_pkg::REL_W'(other_up_x) - ortest_pkg::REL_W'(self_base_x);
        cy[2] = ortest_pkg::REL_W'(other_up_y) - ortest_pkg::REL_W'(self_base_y);
        // fourth corner: side + up - base, taken relative to our base
        cx[3] = ortest_pkg::REL_W'(other_side_x) + ortest_pkg::REL_W'(other_up_x)
              - ortest_pkg::REL_W'(other_base_x) - ortest_pkg::REL_W'(self_base_x);
        cy[3] = ortest_pkg::REL_W'(other_side_y) + ortest_pkg::REL_W'(other_up_y)
              - ortest_pkg::REL_W'(other_base_y) - ortest_pkg::REL_W'(self_base_y);

        side_lane_next.ex = side_ex;
        side_lane_next.ey = side_ey;
        up_lane_next.ex   = up_ex;
        up_lane_next.ey   = up_ey;
        for (int k = 0; k < ortest_pkg::CORNERS; k++)
        begin
            side_lane_next.qx[k] = cx[k];
            side_lane_next.qy[k] = cy[k];
            up_lane_next.qx[k]   = cx[k];
            up_lane_next.qy[k]   = cy[k];
        end
    end

    always_ff @(posedge clk)
    begin
        side_lane_reg <= side_lane_next;
        up_lane_reg   <= up_lane_next;
    end

    assign side_lane = side_lane_reg;
    assign up_lane   = up_lane_reg;

endmodule

@@ design/ortest_axis_lane.sv @@
`timescale 1ns / 1ps
// One candidate separating axis: projections of four corners, squared edge
// length and the separation verdict over four register stages. Depends on ortest_pkg.

module ortest_axis_lane (
    input  logic                  clk,
    input  ortest_pkg::lane_in_t  lane_in,
    output logic                  separated
);

    logic signed [ortest_pkg::PROD_W-1:0] px_next [ortest_pkg::CORNERS];
    logic signed [ortest_pkg::PROD_W-1:0] py_next [ortest_pkg::CORNERS];
    logic signed [ortest_pkg::PROD_W-1:0] px_reg  [ortest_pkg::CORNERS];
    logic signed [ortest_pkg::PROD_W-1:0] py_reg  [ortest_pkg::CORNERS];
    logic signed [2*ortest_pkg::EDGE_W-1:0] lx_next;
    logic signed [2*ortest_pkg::EDGE_W-1:0] ly_next;
    logic signed [2*ortest_pkg::EDGE_W-1:0] lx_reg;
    logic signed [2*ortest_pkg::EDGE_W-1:0] ly_reg;

    logic signed [ortest_pkg::DOT_W-1:0] dot_next [ortest_pkg::CORNERS];
    logic signed [ortest_pkg::DOT_W-1:0] dot_reg  [ortest_pkg::CORNERS];
    logic signed [ortest_pkg::LEN_W-1:0] len_next;
    logic signed [ortest_pkg::LEN_W-1:0] len_reg;

    logic [ortest_pkg::CORNERS-1:0] above_next;
    logic [ortest_pkg::CORNERS-1:0] below_next;
    logic [ortest_pkg::CORNERS-1:0] above_reg;
    logic [ortest_pkg::CORNERS-1:0] below_reg;
    logic sep_next;
    logic sep_reg;

    // products
    always_comb
    begin
        for (int k = 0; k < ortest_pkg::CORNERS; k++)
        begin
            px_next[k] = $signed(lane_in.qx[k]) * $signed(lane_in.ex);
            py_next[k] = $signed(lane_in.qy[k]) * $signed(lane_in.ey);
        end
        lx_next = $signed(lane_in.ex) * $signed(lane_in.ex);
        ly_next = $signed(lane_in.ey) * $signed(lane_in.ey);
    end

    // dot products and squared length
    always_comb
    begin
        for (int k = 0; k < ortest_pkg::CORNERS; k++)
        begin
            dot_next[k] = ortest_pkg::DOT_W'(px_reg[k]) + ortest_pkg::DOT_W'(py_reg[k]);
        end
        len_next = ortest_pkg::LEN_W'(lx_reg) + ortest_pkg::LEN_W'(ly_reg);
    end

    // min > len2 means every projection is past the far end; max < 0 the near end
    always_comb
    begin
        for (int k = 0; k < ortest_pkg::CORNERS; k++)
        begin
            above_next[k] = dot_reg[k] > ortest_pkg::DOT_W'(len_reg);
            below_next[k] = dot_reg[k][ortest_pkg::DOT_W-1];
        end
        sep_next = (&above_reg) | (&below_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        lx_reg    <= lx_next;
        ly_reg    <= ly_next;
        dot_reg   <= dot_next;
        len_reg   <= len_next;
        above_reg <= above_next;
        below_reg <= below_next;
        sep_reg   <= sep_next;
    end

    assign separated = sep_reg;

endmodule

@@ design/oriented_rectangle_overlap_test_unit.sv @@
`timescale 1ns / 1ps
// Top level of the oriented rectangle overlap test: two front stages, four
// axis lanes and the result register. Depends on ortest_pkg, ortest_front, ortest_axis_lane.
//
// Usage:
// - Drive the twelve corner coordinates and pulse start. A transfer happens at
//   every rising edge with start high and busy low; busy is always low, so a
//   new pair of rectangles may enter in every cycle.
// - Each rectangle is a base corner plus its side and up neighbours; the
//   fourth corner is side + up - base. Touching counts as overlap.
// - done rises when the result register takes the verdict and stays high for exactly one
//   cycle with overlap valid, after the front, lane and result registers.
//   Throughput is one test per cycle.
// - Latency is set by the pipeline: front differences, products, dot sums,
//   per-corner compares, per-axis verdict, combined result.
// - Results leave in transfer order and cannot be held off; the receiver
//   must take each one in the cycle done is high.
// - Reset clears the valid pipeline only; no result appears for items in
//   flight when rst_n drops.

module oriented_rectangle_overlap_test_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ortest_pkg::coord_t first_base_x,
    input  ortest_pkg::coord_t first_base_y,
    input  ortest_pkg::coord_t first_side_x,
    input  ortest_pkg::coord_t first_side_y,
    input  ortest_pkg::coord_t first_up_x,
    input  ortest_pkg::coord_t first_up_y,
    input  ortest_pkg::coord_t second_base_x,
    input  ortest_pkg::coord_t second_base_y,
    input  ortest_pkg::coord_t second_side_x,
    input  ortest_pkg::coord_t second_side_y,
    input  ortest_pkg::coord_t second_up_x,
    input  ortest_pkg::coord_t second_up_y,
    output logic               done,
    output logic               overlap
);

    ortest_pkg::lane_in_t           lane_in [ortest_pkg::LANES];
    logic [ortest_pkg::LANES-1:0]   sep;
    logic [ortest_pkg::LATENCY-1:0] valid_reg;
    logic [ortest_pkg::LATENCY-1:0] valid_next;
    logic                           overlap_reg;
    logic                           overlap_next;

    assign busy = 1'b0;

    // axes of the first rectangle, tested against the second one's corners
    ortest_front u_front_first (
        .clk          (clk),
        .self_base_x  (first_base_x),
        .self_base_y  (first_base_y),
        .self_side_x  (first_side_x),
        .self_side_y  (first_side_y),
        .self_up_x    (first_up_x),
        .self_up_y    (first_up_y),
        .other_base_x (second_base_x),
        .other_base_y (second_base_y),
        .other_side_x (second_side_x),
        .other_side_y (second_side_y),
        .other_up_x   (second_up_x),
        .other_up_y   (second_up_y),
        .side_lane    (lane_in[0]),
        .up_lane      (lane_in[1])
    );

    ortest_front u_front_second (
        .clk          (clk),
        .self_base_x  (second_base_x),
        .self_base_y  (second_base_y),
        .self_side_x  (second_side_x),
        .self_side_y  (second_side_y),
        .self_up_x    (second_up_x),
        .self_up_y    (second_up_y),
        .other_base_x (first_base_x),
        .other_base_y (first_base_y),
        .other_side_x (first_side_x),
        .other_side_y (first_side_y),
        .other_up_x   (first_up_x),
        .other_up_y   (first_up_y),
        .side_lane    (lane_in[2]),
        .up_lane      (lane_in[3])
    );

    for (genvar g = 0; g < ortest_pkg::LANES; g++)
    begin : g_lane
        ortest_axis_lane u_lane (
            .clk       (clk),
            .lane_in   (lane_in[g]),
            .separated (sep[g])
        );
    end

    always_comb
    begin
        valid_next   = {valid_reg[ortest_pkg::LATENCY-2:0], start & ~busy};
        overlap_next = ~(|sep);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        overlap_reg <= overlap_next;
    end

    assign done    = valid_reg[ortest_pkg::LATENCY-1];
    assign overlap = overlap_reg;

endmodule

@@ test/ortest_overlap_checker.sv @@
`timescale 1ns / 1ps
// Checker for the oriented rectangle overlap test unit: watches the transfer and
// result channels, predicts each verdict and compares. Depends on ortest_pkg.

module ortest_overlap_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  ortest_pkg::coord_t first_base_x,
    input  ortest_pkg::coord_t first_base_y,
    input  ortest_pkg::coord_t first_side_x,
    input  ortest_pkg::coord_t first_side_y,
    input  ortest_pkg::coord_t first_up_x,
    input  ortest_pkg::coord_t first_up_y,
    input  ortest_pkg::coord_t second_base_x,
    input  ortest_pkg::coord_t second_base_y,
    input  ortest_pkg::coord_t second_side_x,
    input  ortest_pkg::coord_t second_side_y,
    input  ortest_pkg::coord_t second_up_x,
    input  ortest_pkg::coord_t second_up_y,
    input  logic               done,
    input  logic               overlap,
    output int                 fail_count,
    output int                 pending_count,
    output int                 transfer_count,
    output int                 verdict_count,
    output int                 overlap_count
);

    typedef struct packed {
        ortest_pkg::coord_t bx;
        ortest_pkg::coord_t by;
        ortest_pkg::coord_t sx;
        ortest_pkg::coord_t sy;
        ortest_pkg::coord_t ux;
        ortest_pkg::coord_t uy;
    } corners_t;

    // wide enough for every difference, product and dot sum without loss
    typedef logic signed [2*ortest_pkg::COORD_WIDTH+8:0] span_t;

    typedef struct {
        bit          overlap;
        int unsigned tag;
    } verdict_t;

    verdict_t verdict_q[$];
    verdict_t head;
    verdict_t fresh;
    corners_t first_r;
    corners_t second_r;
    int       n_fail      = 0;
    int       n_transfers = 0;
    int       n_verdicts  = 0;
    int       n_overlaps  = 0;

    assign first_r  = {first_base_x, first_base_y, first_side_x,
                       first_side_y, first_up_x, first_up_y};
    assign second_r = {second_base_x, second_base_y, second_side_x,
                       second_side_y, second_up_x, second_up_y};

    // True when neither edge axis of self_r separates other_r from it.
    function automatic bit axes_hold(input corners_t self_r, input corners_t other_r);
        span_t qx[4];
        span_t qy[4];
        span_t ox;
        span_t oy;
        span_t ex;
        span_t ey;
        span_t len2;
        span_t proj;
        span_t lo;
        span_t hi;
        bit    clear;
        int    axis;
        int    k;
        qx[0] = other_r.bx;
        qy[0] = other_r.by;
        qx[1] = other_r.sx;
        qy[1] = other_r.sy;
        qx[2] = other_r.ux;
        qy[2] = other_r.uy;
        qx[3] = qx[1] + qx[2] - qx[0];
        qy[3] = qy[1] + qy[2] - qy[0];
        ox = self_r.bx;
        oy = self_r.by;
        clear = 1'b1;
        for (axis = 0; axis < 2; axis++)
        begin
            if (axis == 0)
            begin
                ex = self_r.sx;
                ey = self_r.sy;
            end
            else
            begin
                ex = self_r.ux;
                ey = self_r.uy;
            end
            ex = ex - ox;
            ey = ey - oy;
            len2 = ex * ex + ey * ey;
            for (k = 0; k < 4; k++)
            begin
                proj = (qx[k] - ox) * ex + (qy[k] - oy) * ey;
                if (k == 0 || proj < lo)
                    lo = proj;
                if (k == 0 || proj > hi)
                    hi = proj;
            end
            // touching at either bound still counts as overlap
            if (lo > len2 || hi < 0)
                clear = 1'b0;
        end
        return clear;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        n_fail++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result strobe with no transfer outstanding");
                else
                begin
                    head = verdict_q.pop_front();
                    n_verdicts++;
                    if (overlap === 1'b1)
                        n_overlaps++;
                    if (overlap !== head.overlap)
                        report_mismatch($sformatf("transfer %0d: overlap %b, predicted %b",
                                                  head.tag, overlap, head.overlap));
                end
            end
            else if (done !== 1'b0)
                report_mismatch("result strobe is unknown");

            if (start === 1'b1 && busy === 1'b0)
            begin
                fresh.overlap = axes_hold(first_r, second_r) && axes_hold(second_r, first_r);
                fresh.tag     = n_transfers;
                verdict_q.push_back(fresh);
                n_transfers++;
            end
        end
        fail_count     <= n_fail;
        pending_count  <= verdict_q.size();
        transfer_count <= n_transfers;
        verdict_count  <= n_verdicts;
        overlap_count  <= n_overlaps;
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the oriented rectangle overlap test unit: clock, reset,
// stimulus and verdict. Depends on ortest_pkg, the unit and ortest_overlap_checker.

module tb_top;

    localparam int RANDOM_PAIRS = 1900;
    localparam int STALL_LIMIT  = 1000;

    typedef struct packed {
        ortest_pkg::coord_t bx;
        ortest_pkg::coord_t by;
        ortest_pkg::coord_t sx;
        ortest_pkg::coord_t sy;
        ortest_pkg::coord_t ux;
        ortest_pkg::coord_t uy;
    } rect_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    ortest_pkg::coord_t first_base_x;
    ortest_pkg::coord_t first_base_y;
    ortest_pkg::coord_t first_side_x;
    ortest_pkg::coord_t first_side_y;
    ortest_pkg::coord_t first_up_x;
    ortest_pkg::coord_t first_up_y;
    ortest_pkg::coord_t second_base_x;
    ortest_pkg::coord_t second_base_y;
    ortest_pkg::coord_t second_side_x;
    ortest_pkg::coord_t second_side_y;
    ortest_pkg::coord_t second_up_x;
    ortest_pkg::coord_t second_up_y;
    logic               done;
    logic               overlap;

    int fail_count;
    int pending_count;
    int transfer_count;
    int verdict_count;
    int overlap_count;
    int sent_pairs  = 0;
    int idle_cycles = 0;

    oriented_rectangle_overlap_test_unit dut (.*);

    ortest_overlap_checker verdict_mon (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    function automatic rect_t rect_of(input int bx, input int by, input int sx,
                                      input int sy, input int ux, input int uy);
        rect_t r;
        r.bx = ortest_pkg::coord_t'(bx);
        r.by = ortest_pkg::coord_t'(by);
        r.sx = ortest_pkg::coord_t'(sx);
        r.sy = ortest_pkg::coord_t'(sy);
        r.ux = ortest_pkg::coord_t'(ux);
        r.uy = ortest_pkg::coord_t'(uy);
        return r;
    endfunction

    // width edge along (dx,dy)*w, height edge along the perpendicular times h
    function automatic rect_t oriented(input int bx, input int by, input int dx,
                                       input int dy, input int w, input int h);
        return rect_of(bx, by, bx + dx * w, by + dy * w, bx - dy * h, by + dx * h);
    endfunction

    function automatic rect_t collapsed(input int cx, input int cy);
        int sx;
        int sy;
        int ux;
        int uy;
        sx = $urandom_range(0, 1) ? cx : cx + spread(50);
        sy = $urandom_range(0, 1) ? cy : cy + spread(50);
        ux = $urandom_range(0, 1) ? cx : cx + spread(50);
        uy = $urandom_range(0, 1) ? cy : cy + spread(50);
        return rect_of(cx, cy, sx, sy, ux, uy);
    endfunction

    task automatic random_pair(output rect_t a, output rect_t b);
        int kind;
        int bx;
        int by;
        int dx;
        int dy;
        int w;
        int h;
        int g;
        int t;
        kind = $urandom_range(0, 99);
        bx = spread(6000);
        by = spread(6000);
        if (kind < 55)
        begin
            // two freely rotated rectangles near one another
            if ($urandom_range(0, 3) == 0)
            begin
                dx = spread(4);
                dy = spread(4);
                w  = spread(1000);
                h  = spread(1000);
            end
            else
            begin
                dx = spread(64);
                dy = spread(64);
                w  = spread(100);
                h  = spread(100);
            end
            a = oriented(bx, by, dx, dy, w, h);
            b = oriented(bx + spread(6000), by + spread(6000), spread(64), spread(64),
                         spread(100), spread(100));
        end
        else if (kind < 72)
        begin
            // same orientation, abutting or one step off along the width axis
            dx = spread(40);
            dy = spread(40);
            w  = $urandom_range(0, 150);
            h  = spread(150);
            g  = spread(1);
            t  = spread(150);
            a = oriented(bx, by, dx, dy, w, h);
            b = oriented(bx + (w + g) * dx - t * dy, by + (w + g) * dy + t * dx,
                         dx, dy, $urandom_range(0, 150), spread(150));
        end
        else if (kind < 82)
        begin
            bx = spread(60);
            by = spread(60);
            a = collapsed(bx, by);
            b = collapsed(bx + spread(40), by + spread(40));
        end
        else if (kind < 94)
        begin
            a = rect_t'({$urandom(), $urandom(), $urandom()});
            b = rect_t'({$urandom(), $urandom(), $urandom()});
        end
        else
        begin
            a = rect_of(extreme_coord(), extreme_coord(), extreme_coord(),
                        extreme_coord(), extreme_coord(), extreme_coord());
            b = rect_of(extreme_coord(), extreme_coord(), extreme_coord(),
                        extreme_coord(), extreme_coord(), extreme_coord());
        end
    endtask

    // drive at the falling edge, hold until the transfer edge
    task automatic send_pair(input rect_t a, input rect_t b);
        @(negedge clk);
        {first_base_x, first_base_y, first_side_x,
         first_side_y, first_up_x, first_up_y} <= a;
        {second_base_x, second_base_y, second_side_x,
         second_side_y, second_up_x, second_up_y} <= b;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_pairs++;
    endtask

    // drop start and scramble the coordinates at each falling edge it waits
    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            {first_base_x, first_base_y, first_side_x,
             first_side_y, first_up_x, first_up_y} <= {$urandom(), $urandom(), $urandom()};
            {second_base_x, second_base_y, second_side_x,
             second_side_y, second_up_x, second_up_y} <= {$urandom(), $urandom(), $urandom()};
        end
    endtask

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer or result for %0d cycles", STALL_LIMIT);
            $display("** oriented_rectangle_overlap_test_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rect_t first_rect;
        rect_t second_rect;
        int    burst;
        int    directed_pairs;
        rst_n = 1'b0;
        start = 1'b0;
        {first_base_x, first_base_y, first_side_x,
         first_side_y, first_up_x, first_up_y} = '0;
        {second_base_x, second_base_y, second_side_x,
         second_side_y, second_up_x, second_up_y} = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        hold_off(2);

        // identical, apart, edge contact, one unit gap, corner contact
        send_pair(rect_of(0, 0, 10, 0, 0, 10), rect_of(0, 0, 10, 0, 0, 10));
        send_pair(rect_of(0, 0, 10, 0, 0, 10), rect_of(20, 20, 30, 20, 20, 30));
        send_pair(rect_of(0, 0, 10, 0, 0, 10), rect_of(10, 0, 20, 0, 10, 10));
        send_pair(rect_of(0, 0, 10, 0, 0, 10), rect_of(11, 0, 21, 0, 11, 10));
        send_pair(rect_of(0, 0, 10, 0, 0, 10), rect_of(10, 10, 20, 10, 10, 20));
        // zero-length edges: coincident points, distinct points, segments
        send_pair(rect_of(0, 0, 0, 0, 0, 0), rect_of(0, 0, 0, 0, 0, 0));
        send_pair(rect_of(0, 0, 0, 0, 0, 0), rect_of(5, 5, 5, 5, 5, 5));
        send_pair(rect_of(0, 0, 10, 0, 0, 0), rect_of(2, -5, 8, -5, 2, 5));
        send_pair(rect_of(0, 0, 10, 0, 0, 0), rect_of(20, 20, 30, 20, 20, 30));
        // diamond whose own edge separates a square its bounding box overlaps
        send_pair(rect_of(0, 10, 10, 0, 10, 20), rect_of(16, 16, 26, 16, 16, 26));
        send_pair(rect_of(16, 16, 26, 16, 16, 26), rect_of(0, 10, 10, 0, 10, 20));
        // containment, crossing bars, swapped edge order
        send_pair(rect_of(-100, -100, 100, -100, -100, 100), rect_of(-1, -1, 1, -1, -1, 1));
        send_pair(rect_of(-50, -5, 50, -5, -50, 5), rect_of(-5, -50, 5, -50, -5, 50));
        send_pair(rect_of(0, 0, 0, 10, 10, 0), rect_of(5, 5, 15, 5, 5, 15));
        // corners that are no rectangle
        send_pair(rect_of(0, 0, 10, 3, 4, 12), rect_of(12, 12, 20, 14, 9, 20));
        send_pair(rect_of(0, 0, 10, 3, 4, 12), rect_of(30, 0, 20, 14, 9, 20));
        // coordinate extremes, fourth corner beyond the coordinate range
        send_pair(rect_of(32767, 32767, 32767, 32767, 32767, 32767),
                  rect_of(32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(rect_of(-32768, -32768, -32768, -32768, -32768, -32768),
                  rect_of(-32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(rect_of(-32768, -32768, 32767, -32768, -32768, 32767),
                  rect_of(32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(rect_of(-32768, -32768, 32767, -32768, -32768, 32767),
                  rect_of(32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(rect_of(32767, -32768, -32768, 32767, 32767, 32767),
                  rect_of(-32768, 32767, -32768, -32768, 32767, -32768));
        directed_pairs = sent_pairs;
        hold_off(3);

        while (sent_pairs < directed_pairs + RANDOM_PAIRS)
        begin
            burst = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
            repeat (burst)
            begin
                random_pair(first_rect, second_rect);
                send_pair(first_rect, second_rect);
            end
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 12));
        end
        hold_off(1);

        while (pending_count != 0)
            @(posedge clk);
        repeat (ortest_pkg::LATENCY + 4) @(posedge clk);

        $display("Run covered %0d rectangle pairs, %0d of them directed corner cases.",
                 transfer_count, directed_pairs);
        $display("Checked %0d verdicts: %0d overlapping, %0d separated.",
                 verdict_count, overlap_count, verdict_count - overlap_count);
        if (fail_count == 0)
            $display("** oriented_rectangle_overlap_test_unit: PASSED **");
        else
            $display("** oriented_rectangle_overlap_test_unit: FAILED **");
        $finish;
    end

endmodule
